// ===== hdl/smr_pkg.sv =====
// ----------------------------------------------------------------------------
// smr_pkg
// Shared types and constants of the servo motion ramp: field widths, limits,
// opcodes, controller states and the command and status groups.
// ----------------------------------------------------------------------------
package smr_pkg;

	localparam int PULSE_W = 12;
	localparam int CHAN_W  = 4;
	localparam int TIME_W  = 16;
	localparam int MT_W    = 15;
	localparam int STEPS_W = 11;
	localparam int CNT_W   = 4;

	localparam logic [PULSE_W-1:0] PULSE_MIN   = 12'd500;
	localparam logic [PULSE_W-1:0] PULSE_MAX   = 12'd2500;
	localparam logic [PULSE_W-1:0] WIDTH_RESET = 12'd1500;

	localparam logic [TIME_W-1:0] TIME_MIN = 16'd20;
	localparam logic [TIME_W-1:0] TIME_MAX = 16'd30000;

	localparam logic [MT_W-1:0] MOVE_TIME_RESET = 15'd2000;

	localparam logic [CHAN_W-1:0] TOP_CHANNEL = 4'd8;

	// time / 20 = (time >> 2) * RECIP_5 >> RECIP_SHIFT, exact for time <= 30000
	localparam int                RECIP_W     = 12;
	localparam logic [RECIP_W-1:0] RECIP_5    = 12'd3277;
	localparam int                RECIP_SHIFT = 14;

	localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(STEPS_W - 1);

	typedef enum logic {
		OP_SET  = 1'b0,
		OP_TICK = 1'b1
	} opcode_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INIT,
		ST_STEP,
		ST_MUL,
		ST_DIV,
		ST_LOAD
	} state_t;

	typedef enum logic [1:0] {
		MODE_HOLD,
		MODE_INTERP,
		MODE_SNAP
	} mode_t;

	typedef struct packed {
		logic set_wr;
		logic init;
		logic step;
		logic mul;
		logic div;
		logic load;
	} cmd_t;

	typedef struct packed {
		logic pending;
		logic step_interp;
		logic interp;
		logic last_chan;
		logic out_free;
	} sts_t;

endpackage

// ===== hdl/smr_ctrl.sv =====
// ----------------------------------------------------------------------------
// smr_ctrl
// Sequencer of the servo motion ramp: accepts requests, runs the ramp setup
// and the per-channel multiply, serial divide and write-back.
// ----------------------------------------------------------------------------
module smr_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  logic          opcode,
	input  smr_pkg::sts_t sts,
	output smr_pkg::cmd_t cmd
);

	smr_pkg::state_t               state_q;
	smr_pkg::state_t               state_d;
	logic [smr_pkg::CNT_W-1:0]     cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= smr_pkg::ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == smr_pkg::ST_MUL) begin
				cnt_q <= smr_pkg::DIV_LAST;
			end else if (state_q == smr_pkg::ST_DIV) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			smr_pkg::ST_IDLE: begin
				if (in_valid && opcode == smr_pkg::OP_TICK) begin
					state_d = sts.pending ? smr_pkg::ST_INIT : smr_pkg::ST_STEP;
				end
			end
			smr_pkg::ST_INIT: state_d = smr_pkg::ST_STEP;
			smr_pkg::ST_STEP: state_d = sts.step_interp ? smr_pkg::ST_MUL : smr_pkg::ST_LOAD;
			smr_pkg::ST_MUL:  state_d = smr_pkg::ST_DIV;
			smr_pkg::ST_DIV: begin
				if (cnt_q == '0) begin
					state_d = smr_pkg::ST_LOAD;
				end
			end
			smr_pkg::ST_LOAD: begin
				if (sts.out_free) begin
					if (sts.last_chan) begin
						state_d = smr_pkg::ST_IDLE;
					end else begin
						state_d = sts.interp ? smr_pkg::ST_MUL : smr_pkg::ST_LOAD;
					end
				end
			end
			default: state_d = smr_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			smr_pkg::ST_IDLE: begin
				in_stall   = 1'b0;
				cmd.set_wr = in_valid && opcode == smr_pkg::OP_SET;
			end
			smr_pkg::ST_INIT: cmd.init = 1'b1;
			smr_pkg::ST_STEP: cmd.step = 1'b1;
			smr_pkg::ST_MUL:  cmd.mul  = 1'b1;
			smr_pkg::ST_DIV:  cmd.div  = 1'b1;
			smr_pkg::ST_LOAD: cmd.load = sts.out_free;
			default: cmd = '0;
		endcase
	end

	a_div_ends: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == smr_pkg::ST_DIV && cnt_q == '0 |=> state_q == smr_pkg::ST_LOAD)
		else $error("divide did not end in write-back");

endmodule

// ===== hdl/smr_datapath.sv =====
// ----------------------------------------------------------------------------
// smr_datapath
// Channel state, ramp counters, offset multiply, serial divider and the
// output register of the servo motion ramp.
// ----------------------------------------------------------------------------
module smr_datapath #(
	parameter int NUM_CHANNELS = 9
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  smr_pkg::cmd_t                 cmd,
	output smr_pkg::sts_t                 sts,
	input  logic [smr_pkg::CHAN_W-1:0]    channel,
	input  logic [smr_pkg::PULSE_W-1:0]   pulse_us,
	input  logic [smr_pkg::TIME_W-1:0]    move_ms,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [smr_pkg::CHAN_W-1:0]    out_channel,
	output logic [smr_pkg::PULSE_W-1:0]   width_us,
	output logic                          last
);

	localparam int KW    = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam int PW    = smr_pkg::PULSE_W;
	localparam int SW    = smr_pkg::STEPS_W;
	localparam int QW    = smr_pkg::MT_W - 2;
	localparam int TP_W  = QW + smr_pkg::RECIP_W;
	localparam int MP_W  = PW + SW;

	logic [PW-1:0]              target_q  [NUM_CHANNELS];
	logic [PW-1:0]              current_q [NUM_CHANNELS];
	logic signed [PW-1:0]       offset_q  [NUM_CHANNELS];
	logic [smr_pkg::MT_W-1:0]   move_time_q;
	logic [SW-1:0]              total_q;
	logic [SW-1:0]              steps_left_q;
	logic                       pending_q;
	logic                       moving_q;
	smr_pkg::mode_t             mode_q;
	logic [KW-1:0]              k_q;
	logic [SW-1:0]              rem_q;
	logic [SW-1:0]              dq_q;
	logic                       neg_q;
	logic                       out_valid_q;
	logic [smr_pkg::CHAN_W-1:0] out_channel_q;
	logic [PW-1:0]              width_q;
	logic                       last_q;

	logic                       set_ok;
	logic [smr_pkg::TIME_W-1:0] time_cl;
	logic [KW-1:0]              set_idx;
	logic [TP_W-1:0]            total_prod;
	logic [SW-1:0]              total_new;
	logic [SW-1:0]              left_dec;
	logic                       step_interp;
	logic [PW-1:0]              off_bits;
	logic [PW-1:0]              off_mag;
	logic [MP_W-1:0]            mag_prod;
	logic [SW:0]                trial;
	logic [SW:0]                diff;
	logic                       ge;
	logic [PW-1:0]              delta;
	logic [PW-1:0]              tgt_k;
	logic [PW-1:0]              new_w;
	logic                       last_chan;
	logic                       out_free;

	assign set_ok = channel >= 4'd1 && channel <= smr_pkg::TOP_CHANNEL &&
	                ({28'd0, channel} < 32'(NUM_CHANNELS)) &&
	                pulse_us >= smr_pkg::PULSE_MIN && pulse_us <= smr_pkg::PULSE_MAX;
	assign time_cl = (move_ms < smr_pkg::TIME_MIN) ? smr_pkg::TIME_MIN :
	                 (move_ms > smr_pkg::TIME_MAX) ? smr_pkg::TIME_MAX : move_ms;
	assign set_idx = KW'(channel);

	assign total_prod = TP_W'(move_time_q[smr_pkg::MT_W-1:2]) * TP_W'(smr_pkg::RECIP_5);
	assign total_new  = total_prod[smr_pkg::RECIP_SHIFT +: SW];

	assign left_dec    = (steps_left_q == '0) ? '0 : steps_left_q - 1'b1;
	assign step_interp = moving_q && left_dec != '0 && total_q != '0;

	assign off_bits = offset_q[k_q];
	assign off_mag  = off_bits[PW-1] ? (~off_bits + 1'b1) : off_bits;
	assign mag_prod = MP_W'(off_mag) * MP_W'(steps_left_q);

	assign trial = {rem_q, dq_q[SW-1]};
	assign diff  = trial - {1'b0, total_q};
	assign ge    = trial >= {1'b0, total_q};

	assign delta = neg_q ? (~PW'(dq_q) + 1'b1) : PW'(dq_q);
	assign tgt_k = target_q[k_q];

	always_comb begin
		unique case (mode_q)
			smr_pkg::MODE_HOLD:   new_w = current_q[k_q];
			smr_pkg::MODE_INTERP: new_w = tgt_k + delta;
			smr_pkg::MODE_SNAP:   new_w = tgt_k;
			default:              new_w = current_q[k_q];
		endcase
	end

	assign last_chan = k_q == KW'(NUM_CHANNELS - 1);
	assign out_free  = !out_valid_q || !out_stall;

	assign sts.pending     = pending_q;
	assign sts.step_interp = step_interp;
	assign sts.interp      = mode_q == smr_pkg::MODE_INTERP;
	assign sts.last_chan   = last_chan;
	assign sts.out_free    = out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				target_q[i]  <= smr_pkg::WIDTH_RESET;
				current_q[i] <= smr_pkg::WIDTH_RESET;
				offset_q[i]  <= '0;
			end
			move_time_q  <= smr_pkg::MOVE_TIME_RESET;
			total_q      <= '0;
			steps_left_q <= '0;
			pending_q    <= 1'b0;
			moving_q     <= 1'b0;
			mode_q       <= smr_pkg::MODE_HOLD;
			k_q          <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cmd.set_wr && set_ok) begin
				target_q[set_idx] <= pulse_us;
				move_time_q       <= time_cl[smr_pkg::MT_W-1:0];
				pending_q         <= 1'b1;
			end
			if (cmd.init) begin
				pending_q    <= 1'b0;
				total_q      <= total_new;
				steps_left_q <= total_new;
				moving_q     <= 1'b1;
				for (int i = 0; i < NUM_CHANNELS; i++) begin
					offset_q[i] <= current_q[i] - target_q[i];
				end
			end
			if (cmd.step) begin
				k_q <= '0;
				if (moving_q) begin
					steps_left_q <= left_dec;
					if (step_interp) begin
						mode_q <= smr_pkg::MODE_INTERP;
					end else begin
						mode_q   <= smr_pkg::MODE_SNAP;
						moving_q <= 1'b0;
					end
				end else begin
					mode_q <= smr_pkg::MODE_HOLD;
				end
			end
			if (cmd.load) begin
				current_q[k_q] <= new_w;
				k_q            <= last_chan ? '0 : k_q + 1'b1;
				out_valid_q    <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			rem_q <= mag_prod[2*SW-1:SW];
			dq_q  <= mag_prod[SW-1:0];
			neg_q <= off_bits[PW-1];
		end else if (cmd.div) begin
			rem_q <= ge ? diff[SW-1:0] : trial[SW-1:0];
			dq_q  <= {dq_q[SW-2:0], ge};
		end
		if (cmd.load) begin
			out_channel_q <= smr_pkg::CHAN_W'(k_q);
			width_q       <= new_w;
			last_q        <= last_chan;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_channel = out_channel_q;
	assign width_us    = width_q;
	assign last        = last_q;

	a_moving_total: assert property (@(posedge clk) disable iff (!arst_n)
		moving_q |-> total_q != '0)
		else $error("ramp running with zero total");

	a_quot_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mul |-> steps_left_q < total_q)
		else $error("steps left not below total at multiply");

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load && mode_q == smr_pkg::MODE_INTERP |-> rem_q < total_q)
		else $error("divider remainder out of range");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_stall && !cmd.load |=> out_valid_q && $stable(width_q))
		else $error("pending result lost");

endmodule

// ===== hdl/servo_motion_ramp_core.sv =====
// ----------------------------------------------------------------------------
// servo_motion_ramp_core
// Linear pulse-width ramp for servo channels stepped by 20 ms frame ticks.
// ----------------------------------------------------------------------------
// Set request: taken while idle, no result.
// Tick request: setup runs the init state (only with a pending change) and
// the step state, then per channel a write-back when holding or snapping, or
// multiply, serial divider and write-back while ramping.
// The next request is taken once the last channel result is registered.
// Reset: all targets and widths 1500 us, offsets 0, move time 2000 ms, idle.
module servo_motion_ramp_core #(
	parameter int NUM_CHANNELS = 9
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        opcode,
	input  logic [smr_pkg::CHAN_W-1:0]  channel,
	input  logic [smr_pkg::PULSE_W-1:0] pulse_us,
	input  logic [smr_pkg::TIME_W-1:0]  move_ms,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [smr_pkg::CHAN_W-1:0]  out_channel,
	output logic [smr_pkg::PULSE_W-1:0] width_us,
	output logic                        last
);

	smr_pkg::cmd_t cmd;
	smr_pkg::sts_t sts;

	smr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.opcode   (opcode),
		.sts      (sts),
		.cmd      (cmd)
	);

	smr_datapath #(
		.NUM_CHANNELS (NUM_CHANNELS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.channel     (channel),
		.pulse_us    (pulse_us),
		.move_ms     (move_ms),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_channel (out_channel),
		.width_us    (width_us),
		.last        (last)
	);

endmodule
